>>> rtl/core/bb3_pkg.sv
// Shared constants, types and reciprocal table for the 3x3 box blur.
package bb3_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int WidthW   = 11;
  localparam int HeightW  = 16;
  localparam int ChanW    = 8;
  localparam int PixW     = 3 * ChanW;
  localparam int SumW     = 12;
  localparam int CntW     = 4;
  localparam int RecipW   = 18;
  localparam int RecipSh  = 18;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  // Accepted item leaving the control stage.
  typedef struct packed {
    logic            valid;
    logic [ColW-1:0] idx;
    logic [PixW-1:0] pix;
    logic [8:0]      mask;   // window slot inside the frame, col*3+row
    logic            emit;
    logic            last;
  } bb3_item_t;

  // ceil(2^18 / (2n)); exact floor division for 2*sum+n below 4600.
  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] n);
    logic [RecipW-1:0] r;
    case (n)
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd5:    r = 18'd26215;
      4'd6:    r = 18'd21846;
      4'd7:    r = 18'd18725;
      4'd8:    r = 18'd16384;
      4'd9:    r = 18'd14564;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/bb3_ctrl.sv
// Frame counters, configuration registers and edge masks per accepted item.
module bb3_ctrl import bb3_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              take_i,
  input  logic              drain_i,
  input  logic [PixW-1:0]   pix_i,
  output logic [ColW-1:0]   idx_o,
  output bb3_item_t         item_o
);

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [ColW-1:0]    in_col_q, out_col_q;
  logic [HeightW-1:0] in_row_q, out_row_q;
  logic               tail_q;
  bb3_item_t          item_q;

  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic               flushing, use_item, col_wrap, emit, last;
  logic [2:0]         row_ok, col_ok;
  logic [8:0]         mask;
  logic [HeightW:0]   out_row_p1;
  logic [WidthW-1:0]  out_col_p1, in_col_p1;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WidthW'(1);
    end else if (width_q > WidthW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q == '0) ? HeightW'(1) : height_q;
  end

  assign flushing   = in_row_q >= h_eff;
  assign use_item   = take_i && !(drain_i && !flushing);
  assign in_col_p1  = {1'b0, in_col_q} + WidthW'(1);
  assign col_wrap   = in_col_p1 >= w_eff;
  assign emit       = tail_q || (in_row_q >= HeightW'(2)) ||
                      ((in_row_q == HeightW'(1)) && (in_col_q != '0));
  assign out_row_p1 = {1'b0, out_row_q} + (HeightW+1)'(1);
  assign out_col_p1 = {1'b0, out_col_q} + WidthW'(1);
  assign last       = (out_row_p1 >= {1'b0, h_eff}) && (out_col_p1 >= w_eff);

  // neighbor row/column above-left (0), center (1), below-right (2)
  assign row_ok[0] = (out_row_q != '0) && (out_row_q <= h_eff);
  assign row_ok[1] = out_row_q < h_eff;
  assign row_ok[2] = out_row_p1 < {1'b0, h_eff};
  assign col_ok[0] = (out_col_q != '0) && ({1'b0, out_col_q} <= w_eff);
  assign col_ok[1] = {1'b0, out_col_q} < w_eff;
  assign col_ok[2] = out_col_p1 < w_eff;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        mask[c*3+r] = col_ok[c] & row_ok[r];
      end
    end
  end

  assign idx_o  = in_col_q;
  assign item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidthW'(MaxWidth);
      height_q  <= HeightW'(1);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      tail_q    <= 1'b0;
      item_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgWidth:  width_q  <= cfg_data_i[WidthW-1:0];
          CfgHeight: height_q <= cfg_data_i[HeightW-1:0];
          default: ;
        endcase
      end
      item_q.valid <= use_item;
      if (use_item) begin
        item_q.idx  <= in_col_q;
        item_q.pix  <= flushing ? '0 : pix_i;
        item_q.mask <= mask;
        item_q.emit <= emit;
        item_q.last <= last;
        if (emit && last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          tail_q    <= 1'b0;
        end else begin
          if (col_wrap) begin
            in_col_q <= '0;
            if (in_row_q < h_eff) begin
              in_row_q <= in_row_q + HeightW'(1);
            end else begin
              tail_q <= 1'b1;
            end
          end else begin
            in_col_q <= in_col_p1[ColW-1:0];
          end
          if (emit) begin
            if (out_col_p1 >= w_eff) begin
              out_col_q <= '0;
              out_row_q <= out_row_p1[HeightW-1:0];
            end else begin
              out_col_q <= out_col_p1[ColW-1:0];
            end
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/bb3_lane.sv
// One color lane: masked window sum, then rounded mean by reciprocal multiply.
module bb3_lane import bb3_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [ChanW-1:0] px_i [9],
  input  logic [8:0]       mask_i,
  input  logic [CntW-1:0]  n_i,
  output logic [ChanW-1:0] avg_o
);

  logic [SumW-1:0]          sum_d, sum_q;
  logic [SumW:0]            num;
  logic [SumW+RecipW:0]     prod;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 9; k++) begin
      sum_d = sum_d + (mask_i[k] ? SumW'(px_i[k]) : SumW'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  // floor((2*sum + n) / (2n))
  assign num   = {sum_q, 1'b0} + (SumW+1)'(n_i);
  assign prod  = (SumW+RecipW+1)'(num) * (SumW+RecipW+1)'(recip(n_i));
  assign avg_o = prod[RecipSh +: ChanW];

endmodule

>>> rtl/core/box_blur_3x3_edge_aware.sv
// Top level of the edge-aware 3x3 box blur over an RGB pixel stream.
// Pixels of one frame enter in raster order, one transfer per clock, and the
// blurred pixels leave in raster order one row plus one pixel later. Each
// channel is the mean of the 3x3 neighbors inside the frame, rounded half up.
// After the final pixel, send frame_width+1 transfers with tuser (drain) set
// to flush; the final output carries tlast. Drains inside the frame are
// dropped. The input takes one transfer per clock in steady state; output
// valid follows the input transfer through a control stage that
// reads the two line memories (registered at the transfer edge), a window
// stage that writes them back and sums the three color lanes, and a divide
// stage that writes a four-entry output queue. Input tready drops only while
// that queue plus items in flight is full, i.e. when the output side stalls.
// Write configuration while idle.
module box_blur_3x3_edge_aware import bb3_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PixW-1:0]   s_axis_tdata,   // in_red, in_green, in_blue
  input  logic              s_axis_tuser,   // drain
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PixW-1:0]   m_axis_tdata,   // out_red, out_green, out_blue
  output logic              m_axis_tlast,   // frame_last
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,    // 0 frame_width, 1 frame_height
  input  logic [15:0]       cfg_data_i
);

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // line memories: row directly above and two rows above
  logic [PixW-1:0] above_mem [MaxWidth];
  logic [PixW-1:0] two_mem   [MaxWidth];
  logic [PixW-1:0] rd_above_q, rd_two_q;

  logic            s_take;
  logic [ColW-1:0] rd_idx;
  bb3_item_t       item_b;

  // window: slot col*3+row, col 2 newest, row 2 current row
  logic [PixW-1:0] win_q [9];
  logic [PixW-1:0] win_d [9];
  logic [PixW-1:0] above_v, two_v;

  // write-back bypass for back-to-back items on the same column
  logic            fwd_vld_q;
  logic [ColW-1:0] fwd_idx_q;
  logic [PixW-1:0] fwd_above_q, fwd_two_q;
  logic            fwd_hit;

  // divide stage
  logic            vc_q, emit_c_q, last_c_q;
  logic [CntW-1:0] n_c_q;
  logic [ChanW-1:0] avg [3];

  // output queue
  logic [PixW:0]    q_mem [QDepth];
  logic [QPtrW-1:0] q_wr_q, q_rd_q;
  logic [QPtrW:0]   q_cnt_q;
  logic             q_push, q_pop;
  logic [QPtrW+1:0] busy;

  assign cfg_ready_o   = 1'b1;
  assign busy          = {1'b0, q_cnt_q} + (QPtrW+2)'(item_b.valid) + (QPtrW+2)'(vc_q);
  assign s_axis_tready = busy < (QPtrW+2)'(QDepth);
  assign s_take        = s_axis_tvalid && s_axis_tready;

  bb3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (s_take),
    .drain_i     (s_axis_tuser),
    .pix_i       (s_axis_tdata),
    .idx_o       (rd_idx),
    .item_o      (item_b)
  );

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      rd_above_q <= above_mem[rd_idx];
      rd_two_q   <= two_mem[rd_idx];
    end
    if (item_b.valid) begin
      above_mem[item_b.idx] <= item_b.pix;
      two_mem[item_b.idx]   <= above_v;
    end
  end

  assign fwd_hit = fwd_vld_q && (fwd_idx_q == item_b.idx);
  assign above_v = fwd_hit ? fwd_above_q : rd_above_q;
  assign two_v   = fwd_hit ? fwd_two_q   : rd_two_q;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win_d[k] = win_q[k+3];
    end
    win_d[6] = two_v;
    win_d[7] = above_v;
    win_d[8] = item_b.pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
      fwd_vld_q <= 1'b0;
      vc_q      <= 1'b0;
    end else begin
      fwd_vld_q <= item_b.valid;
      vc_q      <= item_b.valid;
      if (item_b.valid) begin
        for (int k = 0; k < 9; k++) begin
          win_q[k] <= (item_b.emit && item_b.last) ? '0 : win_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_b.valid) begin
      fwd_idx_q   <= item_b.idx;
      fwd_above_q <= item_b.pix;
      fwd_two_q   <= above_v;
      emit_c_q    <= item_b.emit;
      last_c_q    <= item_b.last;
      n_c_q       <= CntW'($countones(item_b.mask));
    end
  end

  // one lane per color channel
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    logic [ChanW-1:0] px [9];
    always_comb begin
      for (int k = 0; k < 9; k++) begin
        px[k] = win_d[k][ch*ChanW +: ChanW];
      end
    end
    bb3_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (item_b.valid),
      .px_i   (px),
      .mask_i (item_b.mask),
      .n_i    (n_c_q),
      .avg_o  (avg[ch])
    );
  end

  // merge lanes into the output queue
  assign q_push = vc_q && emit_c_q;
  assign q_pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      q_mem[q_wr_q] <= {last_c_q, avg[2], avg[1], avg[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (q_push) begin
        q_wr_q <= q_wr_q + QPtrW'(1);
      end
      if (q_pop) begin
        q_rd_q <= q_rd_q + QPtrW'(1);
      end
      q_cnt_q <= q_cnt_q + (QPtrW+1)'(q_push) - (QPtrW+1)'(q_pop);
    end
  end

  assign m_axis_tvalid = q_cnt_q != '0;
  assign m_axis_tdata  = q_mem[q_rd_q][PixW-1:0];
  assign m_axis_tlast  = q_mem[q_rd_q][PixW];

endmodule
